// ----- src/pmrm_pkg.sv -----
// Types and constants for the polled request/response master.
// No dependencies; used by every module of the block.
package pmrm_pkg;

    localparam int unsigned RX_BUFFER_BYTES = 256;
    localparam logic [8:0]  RX_LIMIT        = 9'(RX_BUFFER_BYTES);

    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQUEST_PERIOD   = 8'd0,
        CFG_RESPONSE_TIMEOUT = 8'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] now_time;
        logic        link_ready;
        logic [8:0]  request_size;
        logic [8:0]  reply_size;
        logic        send_accepted;
        logic [8:0]  bytes_arrived;
        logic        reply_valid;
    } t_in_item;

    typedef struct packed {
        logic        waiting;
        logic        start_send;
        logic        reply_done;
        logic        timed_out;
        logic [8:0]  bytes_wanted;
        logic [31:0] sent_total;
        logic [31:0] good_total;
        logic [31:0] error_total;
        logic [31:0] timeout_total;
        logic [31:0] last_send_time;
        logic [31:0] last_reply_time;
        logic [8:0]  last_reply_bytes;
    } t_out_item;

    typedef struct packed {
        logic [31:0] request_period;
        logic [31:0] response_timeout;
    } t_cfg;

    typedef struct packed {
        logic        wait_flag;
        logic [31:0] sent_count;
        logic [31:0] good_count;
        logic [31:0] fail_count;
        logic [31:0] expiry_count;
        logic [31:0] send_time;
        logic [31:0] reply_time;
        logic [8:0]  reply_bytes;
        logic [8:0]  received_bytes;
        logic [8:0]  target_bytes;
        logic [31:0] deadline_time;
    } t_state;

endpackage

// ----- src/pmrm_cfg.sv -----
// Configuration register file: request period and response timeout.
// Depends on pmrm_pkg.
module pmrm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [pmrm_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [31:0]                    i_wr_data,
    output pmrm_pkg::t_cfg                 o_cfg
);
    import pmrm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_REQUEST_PERIOD:   r_cfg.request_period   <= i_wr_data;
                CFG_RESPONSE_TIMEOUT: r_cfg.response_timeout <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/pmrm_core.sv -----
// Poll state and counters with the single-pass step logic.
// Depends on pmrm_pkg; state advances on each processed transfer.
module pmrm_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  pmrm_pkg::t_in_item  i_item,
    input  pmrm_pkg::t_cfg      i_cfg,
    output pmrm_pkg::t_out_item o_result
);
    import pmrm_pkg::*;

    t_state r_state;
    t_state n_state;

    logic        start, done, tout;
    logic [8:0]  wanted;
    logic [8:0]  limit;
    logic [8:0]  clip;
    logic [8:0]  recv_sum;
    logic        period_ok;
    logic        size_bad;
    logic [31:0] since_dl;

    always_comb begin
        n_state   = r_state;
        start     = 1'b0;
        done      = 1'b0;
        tout      = 1'b0;
        wanted    = '0;
        clip      = '0;
        recv_sum  = r_state.received_bytes;
        limit     = (r_state.target_bytes == '0 || r_state.target_bytes > RX_LIMIT)
                    ? RX_LIMIT : r_state.target_bytes;
        period_ok = (r_state.sent_count == '0) ||
                    ((i_item.now_time - r_state.send_time) >= i_cfg.request_period);
        size_bad  = (i_item.reply_size == '0) || (i_item.reply_size > RX_LIMIT) ||
                    (i_item.request_size == '0);
        since_dl  = i_item.now_time - r_state.deadline_time;

        if (i_item.link_ready) begin
            if (!r_state.wait_flag) begin
                if (period_ok) begin
                    if (size_bad) begin
                        n_state.fail_count = r_state.fail_count + 32'd1;
                    end else begin
                        start                  = 1'b1;
                        n_state.received_bytes = '0;
                        n_state.target_bytes   = i_item.reply_size;
                        if (!i_item.send_accepted) begin
                            n_state.fail_count = r_state.fail_count + 32'd1;
                        end else begin
                            n_state.sent_count    = r_state.sent_count + 32'd1;
                            n_state.send_time     = i_item.now_time;
                            n_state.wait_flag     = 1'b1;
                            n_state.deadline_time = i_item.now_time + i_cfg.response_timeout;
                        end
                    end
                end
            end else begin
                if (r_state.received_bytes < limit) begin
                    wanted   = limit - r_state.received_bytes;
                    clip     = (i_item.bytes_arrived < wanted) ? i_item.bytes_arrived : wanted;
                    recv_sum = r_state.received_bytes + clip;
                end
                n_state.received_bytes = recv_sum;
                if (r_state.target_bytes != '0 && recv_sum >= r_state.target_bytes) begin
                    done = 1'b1;
                    if (i_item.reply_valid) begin
                        n_state.good_count  = r_state.good_count + 32'd1;
                        n_state.reply_time  = i_item.now_time;
                        n_state.reply_bytes = recv_sum;
                    end else begin
                        n_state.fail_count = r_state.fail_count + 32'd1;
                    end
                    n_state.wait_flag      = 1'b0;
                    n_state.received_bytes = '0;
                    n_state.target_bytes   = '0;
                end else if (!since_dl[31]) begin
                    tout                   = 1'b1;
                    n_state.expiry_count   = r_state.expiry_count + 32'd1;
                    n_state.fail_count     = r_state.fail_count + 32'd1;
                    n_state.wait_flag      = 1'b0;
                    n_state.received_bytes = '0;
                    n_state.target_bytes   = '0;
                end
            end
        end

        o_result.waiting          = n_state.wait_flag;
        o_result.start_send       = start;
        o_result.reply_done       = done;
        o_result.timed_out        = tout;
        o_result.bytes_wanted     = wanted;
        o_result.sent_total       = n_state.sent_count;
        o_result.good_total       = n_state.good_count;
        o_result.error_total      = n_state.fail_count;
        o_result.timeout_total    = n_state.expiry_count;
        o_result.last_send_time   = n_state.send_time;
        o_result.last_reply_time  = n_state.reply_time;
        o_result.last_reply_bytes = n_state.reply_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/polled_request_response_master.sv -----
// Polled request/response master: input register, step logic, result register.
// Input register feeds result register; one item per cycle while output not stalled.
// The next item is taken while a result waits; a stalled output holds the pipeline.
// Reset (i_rst_n low, synchronous) clears state, counters, config and both valid flags.
// Depends on pmrm_pkg, pmrm_cfg and pmrm_core.
module polled_request_response_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pmrm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pmrm_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pmrm_pkg::t_out_item            o_out_data
);
    import pmrm_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item result;
    t_cfg      cfg;
    logic      adv;

    assign o_cfg_ready = 1'b1;
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;

    pmrm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    pmrm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/pmrm_checker.sv -----
// Port-level checks for polled_request_response_master, with its bind.
// Depends on pmrm_pkg.
module pmrm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input pmrm_pkg::t_out_item o_out_data
);
    import pmrm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_done_xor_tout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.reply_done && o_out_data.timed_out))
        else $error("reply done and timeout in one step");

    a_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.start_send |->
            !o_out_data.reply_done && !o_out_data.timed_out && o_out_data.bytes_wanted == '0)
        else $error("send start mixed with receive activity");

endmodule

bind polled_request_response_master pmrm_checker u_pmrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
